### src/teq_pkg.sv
// Shared types and codes for the timer event queue.
package teq_pkg;

	localparam logic REQ_ADD    = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	localparam logic [1:0] FAULT_NONE  = 2'd0;
	localparam logic [1:0] FAULT_FULL  = 2'd1;
	localparam logic [1:0] FAULT_EMPTY = 2'd2;

	typedef struct packed {
		logic        req;
		logic [63:0] expiry;
		logic [31:0] delay;
		logic [31:0] now_lo;
	} cmd_t;

endpackage

### src/teq_front.sv
// Front end: takes requests, forms the expiry time and holds them in a two-entry queue.
module teq_front
	import teq_pkg::*;
#(
	parameter int TAG_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                req_type,
	input  logic [63:0]         now,
	input  logic [31:0]         delay,
	input  logic [TAG_BITS-1:0] event_tag,
	output logic                busy,
	output logic                cmd_valid,
	output cmd_t                cmd,
	output logic [TAG_BITS-1:0] cmd_tag,
	input  logic                pop
);

	cmd_t                slot_cmd_q [2];
	logic [TAG_BITS-1:0] slot_tag_q [2];
	logic                wr_ptr_q;
	logic                rd_ptr_q;
	logic [1:0]          fill_q;
	logic                push;
	cmd_t                wr_cmd;

	assign busy      = (fill_q == 2'd2);
	assign push      = start && !busy;
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd       = slot_cmd_q[rd_ptr_q];
	assign cmd_tag   = slot_tag_q[rd_ptr_q];

	always_comb begin
		wr_cmd.req    = req_type;
		wr_cmd.expiry = now + {32'd0, delay};
		wr_cmd.delay  = delay;
		wr_cmd.now_lo = now[31:0];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_cmd_q[wr_ptr_q] <= wr_cmd;
			slot_tag_q[wr_ptr_q] <= event_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				fill_q <= fill_q + 2'd1;
			else if (pop && !push)
				fill_q <= fill_q - 2'd1;
		end
	end

endmodule

### src/teq_back.sv
// Back end: sorted entry cells with parallel compare, insert/pop shift and result register.
module teq_back
	import teq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int TAG_BITS    = 8,
	localparam int CW         = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  cmd_t                cmd,
	input  logic [TAG_BITS-1:0] cmd_tag,
	output logic                pop,
	output logic                done,
	output logic                fired_valid,
	output logic [TAG_BITS-1:0] fired_tag,
	output logic                reload_valid,
	output logic [31:0]         reload_value,
	output logic                timer_on,
	output logic [1:0]          fault,
	output logic [CW-1:0]       queue_len
);

	localparam logic          ST_IDLE  = 1'b0;
	localparam logic          ST_EXEC  = 1'b1;
	localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

	logic [63:0]         exp_q [QUEUE_DEPTH];
	logic [TAG_BITS-1:0] tag_q [QUEUE_DEPTH];
	logic [CW-1:0]       count_q;
	logic                enabled_q;
	logic                state_q;

	cmd_t                   cmd_s1;
	logic [TAG_BITS-1:0]    tag_s1;
	logic [QUEUE_DEPTH-1:0] lt_s1;
	logic                   head_gt_s1;

	logic                   done_q;
	logic                   fired_valid_q;
	logic [TAG_BITS-1:0]    fired_tag_q;
	logic                   reload_valid_q;
	logic [31:0]            reload_value_q;
	logic [1:0]             fault_q;

	logic [QUEUE_DEPTH-1:0] lt_next;
	logic [QUEUE_DEPTH-1:0] keep;
	logic                   exec;
	logic                   do_add;
	logic                   do_rem;

	assign pop    = cmd_valid && (state_q == ST_IDLE);
	assign exec   = (state_q == ST_EXEC);
	assign do_add = exec && (cmd_s1.req == REQ_ADD) && (count_q != FULL_CNT);
	assign do_rem = exec && (cmd_s1.req == REQ_REMOVE) && (count_q != '0);

	assign done         = done_q;
	assign fired_valid  = fired_valid_q;
	assign fired_tag    = fired_tag_q;
	assign reload_valid = reload_valid_q;
	assign reload_value = reload_value_q;
	assign fault        = fault_q;
	assign timer_on     = enabled_q;
	assign queue_len    = count_q;

	// keep[i]: entry i stays in place on an add
	assign keep[0] = (count_q != '0) && !head_gt_s1;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		assign lt_next[i] = exp_q[i] < cmd.expiry;

		if (i > 0) begin : g_chain
			assign keep[i] = keep[i-1] && (CW'(i) < count_q) && lt_s1[i];
		end

		if (i == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (do_add && !keep[0]) begin
					exp_q[0] <= cmd_s1.expiry;
					tag_q[0] <= tag_s1;
				end else if (do_rem) begin
					exp_q[0] <= exp_q[1];
					tag_q[0] <= tag_q[1];
				end
			end
		end else if (i == QUEUE_DEPTH - 1) begin : g_tail
			always_ff @(posedge clk) begin
				if (do_add && !keep[i]) begin
					exp_q[i] <= keep[i-1] ? cmd_s1.expiry : exp_q[i-1];
					tag_q[i] <= keep[i-1] ? tag_s1 : tag_q[i-1];
				end
			end
		end else begin : g_mid
			always_ff @(posedge clk) begin
				if (do_add && !keep[i]) begin
					exp_q[i] <= keep[i-1] ? cmd_s1.expiry : exp_q[i-1];
					tag_q[i] <= keep[i-1] ? tag_s1 : tag_q[i-1];
				end else if (do_rem) begin
					exp_q[i] <= exp_q[i+1];
					tag_q[i] <= tag_q[i+1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s1     <= cmd;
			tag_s1     <= cmd_tag;
			lt_s1      <= lt_next;
			head_gt_s1 <= exp_q[0] > cmd.expiry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= '0;
			enabled_q      <= 1'b0;
			done_q         <= 1'b0;
			fired_valid_q  <= 1'b0;
			fired_tag_q    <= '0;
			reload_valid_q <= 1'b0;
			reload_value_q <= '0;
			fault_q        <= FAULT_NONE;
		end else begin
			done_q <= exec;
			unique case (state_q)
				ST_IDLE: begin
					if (pop)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q        <= ST_IDLE;
					fired_valid_q  <= 1'b0;
					fired_tag_q    <= '0;
					reload_valid_q <= 1'b0;
					reload_value_q <= '0;
					fault_q        <= FAULT_NONE;
					if (cmd_s1.req == REQ_ADD) begin
						if (count_q == FULL_CNT) begin
							fault_q <= FAULT_FULL;
						end else begin
							count_q <= count_q + CW'(1);
							if (!keep[0]) begin
								reload_valid_q <= 1'b1;
								reload_value_q <= cmd_s1.delay;
								enabled_q      <= 1'b1;
							end
						end
					end else begin
						if (count_q == '0) begin
							fault_q <= FAULT_EMPTY;
						end else begin
							fired_valid_q <= 1'b1;
							fired_tag_q   <= tag_q[0];
							count_q       <= count_q - CW'(1);
							if (count_q == CW'(1)) begin
								enabled_q <= 1'b0;
							end else begin
								reload_valid_q <= 1'b1;
								reload_value_q <= exp_q[1][31:0] - cmd_s1.now_lo;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("pending count above queue depth");

	a_timer_tracks_count: assert property (@(posedge clk) disable iff (!arst_n)
		enabled_q == (count_q != '0))
		else $error("timer enable out of step with pending count");

	a_single_exec: assert property (@(posedge clk) disable iff (!arst_n)
		exec |=> !exec)
		else $error("two update cycles in a row");

	a_done_follows_exec: assert property (@(posedge clk) disable iff (!arst_n)
		exec |=> done_q)
		else $error("update cycle without result strobe");

	a_fire_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && fired_valid_q |-> fault_q == FAULT_NONE)
		else $error("fired event reported with a fault");
`endif

endmodule

### src/timer_event_queue.sv
// Timer event queue top level: front-end request queue feeding the sorted entry back end.
// A request is taken when start is high and busy is low. Requests land in a two-entry queue;
// the back end takes one at a time and ends it before popping the next: a parallel compare
// against all stored expiry times is registered, then the insert or pop shift is done. busy
// rises only when the queue is full. A request moves through the queue slot, the compare
// register and the result register before its result appears, later still for each request
// ahead of it; done is high for exactly one cycle and results must be captured then.
// timer_on and queue_len hold their values between results.
module timer_event_queue
	import teq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int TAG_BITS    = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               req_type,
	input  logic [63:0]                        now,
	input  logic [31:0]                        delay,
	input  logic [TAG_BITS-1:0]                event_tag,
	output logic                               done,
	output logic                               fired_valid,
	output logic [TAG_BITS-1:0]                fired_tag,
	output logic                               reload_valid,
	output logic [31:0]                        reload_value,
	output logic                               timer_on,
	output logic [1:0]                         fault,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]   queue_len
);

	logic                cmd_valid;
	cmd_t                cmd;
	logic [TAG_BITS-1:0] cmd_tag;
	logic                pop;

	teq_front #(
		.TAG_BITS (TAG_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req_type  (req_type),
		.now       (now),
		.delay     (delay),
		.event_tag (event_tag),
		.busy      (busy),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_tag   (cmd_tag),
		.pop       (pop)
	);

	teq_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TAG_BITS    (TAG_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_tag      (cmd_tag),
		.pop          (pop),
		.done         (done),
		.fired_valid  (fired_valid),
		.fired_tag    (fired_tag),
		.reload_valid (reload_valid),
		.reload_value (reload_value),
		.timer_on     (timer_on),
		.fault        (fault),
		.queue_len    (queue_len)
	);

endmodule

### tb/sv/teq_tb_pkg.sv
// Scoreboard for the timer event queue: sorted-queue predictor and result comparison.
package teq_tb_pkg;
	timeunit 1ns;
	timeprecision 1ps;

	import teq_pkg::*;

	localparam int DEPTH = 16;
	localparam int TAG_W = 8;

	typedef struct packed {
		logic             fired_valid;
		logic [TAG_W-1:0] fired_tag;
		logic             reload_valid;
		logic [31:0]      reload_value;
		logic             timer_on;
		logic [1:0]       fault;
		logic [4:0]       queue_len;
	} timer_result_t;

	class timer_queue_model;
		logic [63:0]      expiry_mem [DEPTH];
		logic [TAG_W-1:0] tag_mem [DEPTH];
		int               count;
		logic             enabled;
		timer_result_t    pending_results [$];
		int               errors;
		int               checked;
		int               n_add;
		int               n_remove;
		int               n_head;
		int               n_full;
		int               n_empty;

		function new();
			count = 0;
			enabled = 1'b0;
			errors = 0;
			checked = 0;
			n_add = 0;
			n_remove = 0;
			n_head = 0;
			n_full = 0;
			n_empty = 0;
		endfunction

		function void note_request(logic req, logic [63:0] now_v, logic [31:0] delay_v,
				logic [TAG_W-1:0] tag_v);
			timer_result_t r;
			logic [63:0]   expiry;
			int            pos;
			r = '0;
			if (req == REQ_ADD) begin
				n_add++;
				if (count >= DEPTH) begin
					r.fault = FAULT_FULL;
					n_full++;
				end else begin
					expiry = now_v + {32'd0, delay_v};
					if (count == 0 || expiry_mem[0] > expiry) begin
						pos = 0;
					end else begin
						pos = 1;
						while (pos < count && expiry_mem[pos] < expiry)
							pos++;
					end
					for (int i = count; i > pos; i--) begin
						expiry_mem[i] = expiry_mem[i-1];
						tag_mem[i] = tag_mem[i-1];
					end
					expiry_mem[pos] = expiry;
					tag_mem[pos] = tag_v;
					count++;
					if (pos == 0) begin
						r.reload_valid = 1'b1;
						r.reload_value = delay_v;
						enabled = 1'b1;
						n_head++;
					end
				end
			end else begin
				n_remove++;
				if (count == 0) begin
					r.fault = FAULT_EMPTY;
					n_empty++;
				end else begin
					r.fired_valid = 1'b1;
					r.fired_tag = tag_mem[0];
					for (int i = 1; i < count; i++) begin
						expiry_mem[i-1] = expiry_mem[i];
						tag_mem[i-1] = tag_mem[i];
					end
					count--;
					if (count == 0) begin
						enabled = 1'b0;
					end else begin
						r.reload_valid = 1'b1;
						r.reload_value = expiry_mem[0][31:0] - now_v[31:0];
					end
				end
			end
			r.timer_on = enabled;
			r.queue_len = count[4:0];
			pending_results.push_back(r);
		endfunction

		function void report(string field, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_result(timer_result_t got);
			timer_result_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual 0x%0h", $time, got);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			checked++;
			report("fired_valid", want.fired_valid, got.fired_valid);
			report("fired_tag", want.fired_tag, got.fired_tag);
			report("reload_valid", want.reload_valid, got.reload_valid);
			report("reload_value", want.reload_value, got.reload_value);
			report("timer_on", want.timer_on, got.timer_on);
			report("fault", want.fault, got.fault);
			report("queue_len", want.queue_len, got.queue_len);
		endfunction
	endclass

endpackage

### tb/sv/tb_timer_event_queue.sv
// Testbench top for the timer event queue: directed and random add/remove traffic.
module tb_timer_event_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import teq_pkg::*;
	import teq_tb_pkg::*;

	localparam int N_RANDOM = 750;
	localparam int LIMIT    = 200000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	logic             req_type = 1'b0;
	logic [63:0]      now = '0;
	logic [31:0]      delay = '0;
	logic [TAG_W-1:0] event_tag = '0;
	logic             done;
	logic             fired_valid;
	logic [TAG_W-1:0] fired_tag;
	logic             reload_valid;
	logic [31:0]      reload_value;
	logic             timer_on;
	logic [1:0]       fault;
	logic [4:0]       queue_len;

	timer_queue_model q_model = new();
	int               cycle_count = 0;
	int               sent = 0;

	timer_event_queue #(
		.QUEUE_DEPTH(DEPTH),
		.TAG_BITS(TAG_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.now(now),
		.delay(delay),
		.event_tag(event_tag),
		.done(done),
		.fired_valid(fired_valid),
		.fired_tag(fired_tag),
		.reload_valid(reload_valid),
		.reload_value(reload_value),
		.timer_on(timer_on),
		.fault(fault),
		.queue_len(queue_len)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("tb_timer_event_queue failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			q_model.check_result({fired_valid, fired_tag, reload_valid, reload_value,
				timer_on, fault, queue_len});
	end

	// called at a rising edge; returns at the edge where the transaction is accepted
	task automatic send_request(input logic req, input logic [63:0] now_v,
			input logic [31:0] delay_v, input logic [TAG_W-1:0] tag_v, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= req;
		now <= now_v;
		delay <= delay_v;
		event_tag <= tag_v;
		do @(posedge clk); while (busy);
		q_model.note_request(req, now_v, delay_v, tag_v);
		sent++;
	endtask

	logic [63:0] tick;
	logic [63:0] now_r;
	logic [63:0] diff;
	logic [31:0] delay_r;
	logic        req_r;
	int          add_pct;
	int          epoch_len;
	int          mode;
	int          idx;
	bit          no_gaps;
	int          directed_n;

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(REQ_REMOVE, {$urandom, $urandom}, $urandom, TAG_W'($urandom), 0);
		send_request(REQ_ADD, 64'd0, 32'd0, 8'h00, $urandom_range(0, 6));
		send_request(REQ_ADD, '1, '1, 8'hff, 0);
		send_request(REQ_ADD, 64'd0, 32'd0, 8'h55, $urandom_range(0, 6));
		send_request(REQ_ADD, 64'd5, 32'hffff_fff9, 8'haa, 0);
		send_request(REQ_ADD, 64'h8000_0000_0000_0000, 32'd100, 8'h3c, 0);
		send_request(REQ_REMOVE, 64'h1_0000_0003, $urandom, TAG_W'($urandom),
			$urandom_range(0, 6));
		send_request(REQ_REMOVE, '1, $urandom, TAG_W'($urandom), 0);
		send_request(REQ_ADD, 64'd1, 32'h10, 8'h0f, 0);
		repeat (5)
			send_request(REQ_REMOVE, {$urandom, $urandom}, $urandom, TAG_W'($urandom),
				$urandom_range(0, 6));
		directed_n = sent;

		tick = {$urandom, $urandom} >> 8;
		while (sent < directed_n + N_RANDOM) begin
			case ($urandom_range(0, 3))
				0: add_pct = 90;
				1: add_pct = 60;
				2: add_pct = 40;
				default: add_pct = 15;
			endcase
			epoch_len = $urandom_range(20, 60);
			no_gaps = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0)
				tick = 64'hffff_ffff_ffff_ff00 + $urandom_range(0, 200);
			repeat (epoch_len) begin
				tick = tick + $urandom_range(0, 20);
				req_r = ($urandom_range(0, 99) < add_pct) ? REQ_ADD : REQ_REMOVE;
				now_r = ($urandom_range(0, 99) < 85) ? tick : {$urandom, $urandom};
				mode = $urandom_range(0, 9);
				if (mode <= 3)
					delay_r = $urandom_range(0, 40);
				else if (mode <= 5)
					delay_r = $urandom;
				else if (mode == 6)
					delay_r = $urandom_range(0, 1) ? 32'hffff_ffff : 32'd0;
				else if (q_model.count > 0) begin
					// try to hit an existing expiry exactly
					idx = $urandom_range(0, q_model.count - 1);
					diff = q_model.expiry_mem[idx] - now_r;
					delay_r = (diff[63:32] == 0) ? diff[31:0] : $urandom_range(0, 40);
				end else
					delay_r = $urandom_range(0, 40);
				send_request(req_r, now_r, delay_r, TAG_W'($urandom),
					no_gaps ? 0 : $urandom_range(0, 6));
			end
		end
		start <= 1'b0;

		while (q_model.pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("run: %0d adds (%0d new heads, %0d rejected on full), %0d removes (%0d on empty)",
			q_model.n_add, q_model.n_head, q_model.n_full, q_model.n_remove, q_model.n_empty);
		$display("run: %0d results compared, %0d mismatches", q_model.checked, q_model.errors);
		if (q_model.errors == 0 && q_model.pending_results.size() == 0)
			$display("tb_timer_event_queue passed");
		else
			$display("tb_timer_event_queue failed");
		$finish;
	end

endmodule
